>>> rtl/chrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chrt_pkg
// Types, constants and the multiply-accumulate schedule of the closest-hit
// ray/triangle block.
// ----------------------------------------------------------------------------
package chrt_pkg;

    localparam int IDX_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int CRD_W     = 32;           // coordinate width
    localparam int OPD_W     = CRD_W + 1;    // vertex differences
    localparam int PW        = 2 * OPD_W + 1; // cross product components
    localparam int CHUNK_W   = 34;           // low chunk of a wide operand
    localparam int MB_W      = CHUNK_W + 1;  // multiplier B input
    localparam int PRD_W     = OPD_W + MB_W; // multiplier product
    localparam int ACC_W     = 104;          // dot products and their sums
    localparam int T_W       = 31;
    localparam int BC_W      = 17;
    localparam int TIDX_W    = 16;
    localparam int NUM_MACS  = 24;
    localparam int STEP_W    = 5;

    localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

    // Operand codes of the shared multiplier.
    localparam logic [4:0] OP_E1X  = 5'd0;
    localparam logic [4:0] OP_E1Y  = 5'd1;
    localparam logic [4:0] OP_E1Z  = 5'd2;
    localparam logic [4:0] OP_E2X  = 5'd3;
    localparam logic [4:0] OP_E2Y  = 5'd4;
    localparam logic [4:0] OP_E2Z  = 5'd5;
    localparam logic [4:0] OP_AOX  = 5'd6;
    localparam logic [4:0] OP_AOY  = 5'd7;
    localparam logic [4:0] OP_AOZ  = 5'd8;
    localparam logic [4:0] OP_UX   = 5'd9;
    localparam logic [4:0] OP_UY   = 5'd10;
    localparam logic [4:0] OP_UZ   = 5'd11;
    localparam logic [4:0] OP_N0   = 5'd12;
    localparam logic [4:0] OP_N1   = 5'd13;
    localparam logic [4:0] OP_N2   = 5'd14;
    localparam logic [4:0] OP_AOU0 = 5'd15;
    localparam logic [4:0] OP_AOU1 = 5'd16;
    localparam logic [4:0] OP_AOU2 = 5'd17;

    // Accumulator destinations.
    localparam logic [3:0] D_N0   = 4'd0;
    localparam logic [3:0] D_N1   = 4'd1;
    localparam logic [3:0] D_N2   = 4'd2;
    localparam logic [3:0] D_AOU0 = 4'd3;
    localparam logic [3:0] D_AOU1 = 4'd4;
    localparam logic [3:0] D_AOU2 = 4'd5;
    localparam logic [3:0] D_DEN  = 4'd6;
    localparam logic [3:0] D_BN   = 4'd7;
    localparam logic [3:0] D_GN   = 4'd8;
    localparam logic [3:0] D_TN   = 4'd9;

    typedef struct packed {
        logic signed [OPD_W-1:0] x;
        logic signed [OPD_W-1:0] y;
        logic signed [OPD_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] z;
    } wvec_t;

    typedef struct packed {
        logic [4:0] a_sel;
        logic [4:0] b_sel;
        logic       neg;
        logic       last;
        logic [3:0] dest;
    } mac_op_t;

    typedef struct packed {
        logic       valid;
        logic       neg;
        logic       hi;
        logic       last;
        logic [3:0] dest;
    } acc_ctl_t;

    // N = e1 x e2, AOu = AO x u, den = u.N, bn = -e2.AOu, gn = e1.AOu,
    // tn = -AO.N, one product per step.
    function automatic mac_op_t mac_op(input logic [STEP_W-1:0] step);
        mac_op_t op;
        op = '{OP_E1X, OP_E1X, 1'b0, 1'b0, D_N0};
        unique case (step)
            5'd0:  op = '{OP_E1Y, OP_E2Z, 1'b0, 1'b0, D_N0};
            5'd1:  op = '{OP_E1Z, OP_E2Y, 1'b1, 1'b1, D_N0};
            5'd2:  op = '{OP_E1Z, OP_E2X, 1'b0, 1'b0, D_N1};
            5'd3:  op = '{OP_E1X, OP_E2Z, 1'b1, 1'b1, D_N1};
            5'd4:  op = '{OP_E1X, OP_E2Y, 1'b0, 1'b0, D_N2};
            5'd5:  op = '{OP_E1Y, OP_E2X, 1'b1, 1'b1, D_N2};
            5'd6:  op = '{OP_AOY, OP_UZ, 1'b0, 1'b0, D_AOU0};
            5'd7:  op = '{OP_AOZ, OP_UY, 1'b1, 1'b1, D_AOU0};
            5'd8:  op = '{OP_AOZ, OP_UX, 1'b0, 1'b0, D_AOU1};
            5'd9:  op = '{OP_AOX, OP_UZ, 1'b1, 1'b1, D_AOU1};
            5'd10: op = '{OP_AOX, OP_UY, 1'b0, 1'b0, D_AOU2};
            5'd11: op = '{OP_AOY, OP_UX, 1'b1, 1'b1, D_AOU2};
            5'd12: op = '{OP_UX, OP_N0, 1'b0, 1'b0, D_DEN};
            5'd13: op = '{OP_UY, OP_N1, 1'b0, 1'b0, D_DEN};
            5'd14: op = '{OP_UZ, OP_N2, 1'b0, 1'b1, D_DEN};
            5'd15: op = '{OP_E2X, OP_AOU0, 1'b1, 1'b0, D_BN};
            5'd16: op = '{OP_E2Y, OP_AOU1, 1'b1, 1'b0, D_BN};
            5'd17: op = '{OP_E2Z, OP_AOU2, 1'b1, 1'b1, D_BN};
            5'd18: op = '{OP_E1X, OP_AOU0, 1'b0, 1'b0, D_GN};
            5'd19: op = '{OP_E1Y, OP_AOU1, 1'b0, 1'b0, D_GN};
            5'd20: op = '{OP_E1Z, OP_AOU2, 1'b0, 1'b1, D_GN};
            5'd21: op = '{OP_AOX, OP_N0, 1'b1, 1'b0, D_TN};
            5'd22: op = '{OP_AOY, OP_N1, 1'b1, 1'b0, D_TN};
            5'd23: op = '{OP_AOZ, OP_N2, 1'b1, 1'b1, D_TN};
            default: op = '{OP_E1X, OP_E1X, 1'b0, 1'b0, D_N0};
        endcase
        return op;
    endfunction

endpackage

>>> rtl/closest_hit_ray_triangle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_hit_ray_triangle
// Exact fixed-point ray/triangle test with nearest-hit tracking over a
// stream of triangles.
//
// Channel   Signals                         Direction  Moves
// in        in_valid/in_ready + fields      into       one triangle
// out       out_valid/out_ready + fields    out of     one nearest-hit result
// cfg       cfg_we/cfg_index/cfg_data       into       one register write
//
// A triangle with a zero denominator stops after its products on the one
// shared 33x35 multiplier; one that passes the hit test then takes one
// restoring divide for t and, when it becomes the new nearest hit, one each
// for beta and gamma. A hit that does not beat the kept hit skips those two.
// in_ready is high only while the sequencer is idle. A finished result sits
// in the output register; the sequencer stalls on a last triangle only while
// that register still holds an untaken result. Reset clears the nearest-hit
// state and the ray registers.
// ----------------------------------------------------------------------------
module closest_hit_ray_triangle #(
    parameter int INDEX_BITS = chrt_pkg::IDX_BITS_DEF,
    parameter int FRAC_BITS  = chrt_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [chrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [chrt_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [chrt_pkg::CRD_W-1:0] vert_a_x,
    input  logic signed [chrt_pkg::CRD_W-1:0] vert_a_y,
    input  logic signed [chrt_pkg::CRD_W-1:0] vert_a_z,
    input  logic signed [chrt_pkg::CRD_W-1:0] vert_b_x,
    input  logic signed [chrt_pkg::CRD_W-1:0] vert_b_y,
    input  logic signed [chrt_pkg::CRD_W-1:0] vert_b_z,
    input  logic signed [chrt_pkg::CRD_W-1:0] vert_c_x,
    input  logic signed [chrt_pkg::CRD_W-1:0] vert_c_y,
    input  logic signed [chrt_pkg::CRD_W-1:0] vert_c_z,
    input  logic [chrt_pkg::TIDX_W-1:0]     tri_index,
    input  logic                            last_tri,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit_found,
    output logic [chrt_pkg::T_W-1:0]        hit_t,
    output logic [chrt_pkg::BC_W-1:0]       hit_beta,
    output logic [chrt_pkg::BC_W-1:0]       hit_gamma,
    output logic [chrt_pkg::TIDX_W-1:0]     hit_index
);
    import chrt_pkg::*;

    localparam int DW = ACC_W + 32;
    localparam logic [TIDX_W-1:0] IDX_MASK = (INDEX_BITS >= TIDX_W) ? {TIDX_W{1'b1}}
        : TIDX_W'((64'd1 << INDEX_BITS) - 64'd1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MAC   = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_SIGN  = 4'd3;
    localparam logic [3:0] S_TEST  = 4'd4;
    localparam logic [3:0] S_DIVT  = 4'd5;
    localparam logic [3:0] S_CMPT  = 4'd6;
    localparam logic [3:0] S_DIVB  = 4'd7;
    localparam logic [3:0] S_DIVG  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    // Ray registers.
    logic signed [CRD_W-1:0] org_x_reg, org_y_reg, org_z_reg;
    logic signed [CRD_W-1:0] dir_x_reg, dir_y_reg, dir_z_reg;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic              phase_reg;

    vec_t              e1_reg, e2_reg, ao_reg, u_reg;
    wvec_t             n_reg, aou_reg;
    logic [TIDX_W-1:0] idx_reg;
    logic              last_reg;

    logic signed [PRD_W-1:0] prod_reg;
    acc_ctl_t                ctl_reg, ctl_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] den_reg, bn_reg, gn_reg, tn_reg;

    logic [DW-1:0]      rem_reg, dsh_reg;
    logic [4:0]         cnt_reg;
    logic [T_W-1:0]     q_reg;
    logic               sat_reg;
    logic [T_W-1:0]     t_reg;
    logic [BC_W-1:0]    beta_reg;

    logic [T_W-1:0]     best_t_reg;
    logic [BC_W-1:0]    best_beta_reg, best_gamma_reg;
    logic [TIDX_W-1:0]  best_index_reg;
    logic               any_hit_reg;

    logic               out_valid_reg;
    logic               hit_found_reg;
    logic [T_W-1:0]     hit_t_reg;
    logic [BC_W-1:0]    hit_beta_reg, hit_gamma_reg;
    logic [TIDX_W-1:0]  hit_index_reg;

    mac_op_t                 op;
    logic signed [OPD_W-1:0] mul_a;
    logic signed [PW-1:0]    mul_b;
    logic signed [MB_W-1:0]  chunk;
    logic signed [ACC_W-1:0] term, acc_sum;
    logic                    in_xfer, out_load, div_load, div_done, div_ge;
    logic signed [ACC_W-1:0] div_num;
    logic [ACC_W:0]          bg_sum;
    logic                    hit_ok;
    logic [T_W-1:0]          t_cand;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            dir_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X: org_x_reg <= cfg_data;
                REG_ORIGIN_Y: org_y_reg <= cfg_data;
                REG_ORIGIN_Z: org_z_reg <= cfg_data;
                REG_DIR_X:    dir_x_reg <= cfg_data;
                REG_DIR_Y:    dir_y_reg <= cfg_data;
                REG_DIR_Z:    dir_z_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        op = mac_op(step_reg);
        unique case (op.a_sel)
            OP_E1X:  mul_a = e1_reg.x;
            OP_E1Y:  mul_a = e1_reg.y;
            OP_E1Z:  mul_a = e1_reg.z;
            OP_E2X:  mul_a = e2_reg.x;
            OP_E2Y:  mul_a = e2_reg.y;
            OP_E2Z:  mul_a = e2_reg.z;
            OP_AOX:  mul_a = ao_reg.x;
            OP_AOY:  mul_a = ao_reg.y;
            OP_AOZ:  mul_a = ao_reg.z;
            OP_UX:   mul_a = u_reg.x;
            OP_UY:   mul_a = u_reg.y;
            OP_UZ:   mul_a = u_reg.z;
            default: mul_a = '0;
        endcase
        unique case (op.b_sel)
            OP_E2X:  mul_b = PW'(e2_reg.x);
            OP_E2Y:  mul_b = PW'(e2_reg.y);
            OP_E2Z:  mul_b = PW'(e2_reg.z);
            OP_UX:   mul_b = PW'(u_reg.x);
            OP_UY:   mul_b = PW'(u_reg.y);
            OP_UZ:   mul_b = PW'(u_reg.z);
            OP_N0:   mul_b = n_reg.x;
            OP_N1:   mul_b = n_reg.y;
            OP_N2:   mul_b = n_reg.z;
            OP_AOU0: mul_b = aou_reg.x;
            OP_AOU1: mul_b = aou_reg.y;
            OP_AOU2: mul_b = aou_reg.z;
            default: mul_b = '0;
        endcase
        // The wide operand goes through in two pieces: low bits unsigned,
        // then the signed upper part weighted by 2^CHUNK_W.
        if (phase_reg)
            chunk = MB_W'($signed(mul_b[PW-1:CHUNK_W]));
        else
            chunk = {1'b0, mul_b[CHUNK_W-1:0]};

        ctl_next       = '0;
        ctl_next.valid = (state_reg == S_MAC);
        ctl_next.neg   = op.neg;
        ctl_next.hi    = phase_reg;
        ctl_next.last  = op.last && phase_reg;
        ctl_next.dest  = op.dest;
    end

    // Accumulator input.
    always_comb
    begin
        term = ACC_W'(prod_reg);
        if (ctl_reg.hi)
            term = term <<< CHUNK_W;
        if (ctl_reg.neg)
            acc_sum = acc_reg - term;
        else
            acc_sum = acc_reg + term;
    end

    // Hit test on the sign-normalized numerators.
    always_comb
    begin
        bg_sum = {1'b0, bn_reg} + {1'b0, gn_reg};
        hit_ok = !bn_reg[ACC_W-1] && !gn_reg[ACC_W-1] && !tn_reg[ACC_W-1]
                 && (bg_sum <= {1'b0, den_reg});
    end

    assign t_cand = sat_reg ? T_MAX : q_reg;

    // Divider control.
    always_comb
    begin
        div_load = 1'b0;
        div_num  = tn_reg;
        div_done = (cnt_reg == 5'd0);
        div_ge   = (rem_reg >= dsh_reg);
        if (state_reg == S_TEST && hit_ok)
        begin
            div_load = 1'b1;
            div_num  = tn_reg;
        end
        else if (state_reg == S_CMPT && (!any_hit_reg || t_cand < best_t_reg))
        begin
            div_load = 1'b1;
            div_num  = bn_reg;
        end
        else if (state_reg == S_DIVB && div_done)
        begin
            div_load = 1'b1;
            div_num  = gn_reg;
        end
    end

    assign out_load = (state_reg == S_FIN) && last_reg && (!out_valid_reg || out_ready);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_xfer)
                    state_next = S_MAC;
            S_MAC:
                if (phase_reg && step_reg == STEP_W'(NUM_MACS - 1))
                    state_next = S_DRAIN;
            S_DRAIN:
                state_next = S_SIGN;
            S_SIGN:
                state_next = (den_reg == '0) ? S_FIN : S_TEST;
            S_TEST:
                state_next = hit_ok ? S_DIVT : S_FIN;
            S_DIVT:
                if (div_done)
                    state_next = S_CMPT;
            S_CMPT:
                state_next = div_load ? S_DIVB : S_FIN;
            S_DIVB:
                if (div_done)
                    state_next = S_DIVG;
            S_DIVG:
                if (div_done)
                    state_next = S_FIN;
            S_FIN:
                if (!last_reg || out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            phase_reg      <= 1'b0;
            ctl_reg        <= '0;
            acc_reg        <= '0;
            best_t_reg     <= T_MAX;
            best_beta_reg  <= '0;
            best_gamma_reg <= '0;
            best_index_reg <= '0;
            any_hit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctl_reg   <= ctl_next;

            if (state_reg == S_MAC)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                    step_reg <= step_reg + STEP_W'(1);
            end
            else
            begin
                phase_reg <= 1'b0;
                step_reg  <= '0;
            end

            if (ctl_reg.valid)
                acc_reg <= ctl_reg.last ? '0 : acc_sum;

            // The lowest quotient bit of gamma is decided in this very cycle.
            if (state_reg == S_DIVG && div_done)
            begin
                best_t_reg     <= t_reg;
                best_beta_reg  <= beta_reg;
                best_gamma_reg <= {q_reg[BC_W-1:1], div_ge};
                best_index_reg <= idx_reg & IDX_MASK;
                any_hit_reg    <= 1'b1;
            end

            if (out_load)
            begin
                best_t_reg     <= T_MAX;
                best_beta_reg  <= '0;
                best_gamma_reg <= '0;
                best_index_reg <= '0;
                any_hit_reg    <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            e1_reg.x <= OPD_W'(vert_b_x) - OPD_W'(vert_a_x);
            e1_reg.y <= OPD_W'(vert_b_y) - OPD_W'(vert_a_y);
            e1_reg.z <= OPD_W'(vert_b_z) - OPD_W'(vert_a_z);
            e2_reg.x <= OPD_W'(vert_c_x) - OPD_W'(vert_a_x);
            e2_reg.y <= OPD_W'(vert_c_y) - OPD_W'(vert_a_y);
            e2_reg.z <= OPD_W'(vert_c_z) - OPD_W'(vert_a_z);
            ao_reg.x <= OPD_W'(org_x_reg) - OPD_W'(vert_a_x);
            ao_reg.y <= OPD_W'(org_y_reg) - OPD_W'(vert_a_y);
            ao_reg.z <= OPD_W'(org_z_reg) - OPD_W'(vert_a_z);
            u_reg.x  <= OPD_W'(dir_x_reg);
            u_reg.y  <= OPD_W'(dir_y_reg);
            u_reg.z  <= OPD_W'(dir_z_reg);
            idx_reg  <= tri_index;
            last_reg <= last_tri;
        end

        prod_reg <= mul_a * chunk;

        if (ctl_reg.valid && ctl_reg.last)
        begin
            unique case (ctl_reg.dest)
                D_N0:    n_reg.x   <= acc_sum[PW-1:0];
                D_N1:    n_reg.y   <= acc_sum[PW-1:0];
                D_N2:    n_reg.z   <= acc_sum[PW-1:0];
                D_AOU0:  aou_reg.x <= acc_sum[PW-1:0];
                D_AOU1:  aou_reg.y <= acc_sum[PW-1:0];
                D_AOU2:  aou_reg.z <= acc_sum[PW-1:0];
                D_DEN:   den_reg   <= acc_sum;
                D_BN:    bn_reg    <= acc_sum;
                D_GN:    gn_reg    <= acc_sum;
                D_TN:    tn_reg    <= acc_sum;
                default: ;
            endcase
        end

        // A negative denominator is negated together with every numerator, so the ratios keep their values.
        if (state_reg == S_SIGN && den_reg[ACC_W-1])
        begin
            den_reg <= -den_reg;
            bn_reg  <= -bn_reg;
            gn_reg  <= -gn_reg;
            tn_reg  <= -tn_reg;
        end

        // Restoring divide: the first compare against den * 2^31 only
        // detects saturation, then one quotient bit per cycle.
        if (div_load)
        begin
            rem_reg <= DW'(div_num) << FRAC_BITS;
            dsh_reg <= DW'(den_reg) << (T_W);
            cnt_reg <= 5'(T_W);
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (state_reg == S_DIVT || state_reg == S_DIVB || state_reg == S_DIVG)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
                if (cnt_reg == 5'(T_W))
                    sat_reg <= 1'b1;
                else
                    q_reg[cnt_reg] <= 1'b1;
            end
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - 5'd1;
        end

        if (state_reg == S_CMPT)
            t_reg <= t_cand;
        if (state_reg == S_DIVB && div_done)
            beta_reg <= {q_reg[BC_W-1:1], div_ge};

        if (out_load)
        begin
            hit_found_reg <= any_hit_reg;
            hit_t_reg     <= any_hit_reg ? best_t_reg : '0;
            hit_beta_reg  <= best_beta_reg;
            hit_gamma_reg <= best_gamma_reg;
            hit_index_reg <= best_index_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_found = hit_found_reg;
    assign hit_t     = hit_t_reg;
    assign hit_beta  = hit_beta_reg;
    assign hit_gamma = hit_gamma_reg;
    assign hit_index = hit_index_reg;

    // Saturation needs a t divide; the beta and gamma ratios never saturate.
    // With no hit kept, the nearest t still holds its cleared value.
    a_best_t_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !any_hit_reg |-> best_t_reg == T_MAX)
        else $error("nearest t changed without a hit");

    a_acc_only_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid |-> (state_reg == S_MAC || state_reg == S_DRAIN))
        else $error("accumulator active outside the product phase");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == S_MAC && step_reg == '0)
        else $error("accepted triangle did not start the sequencer");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && !any_hit_reg |-> best_beta_reg == '0 && best_gamma_reg == '0
                                     && best_index_reg == '0)
        else $error("miss result would carry stale fields");

endmodule
